// ----- rtl/sha1_pkg.sv -----
// shared types and constants for the sha-1 message digest block
// channel word structs, sequencer states, initial vector and round constants
// no dependencies
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } sha1_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } sha1_state_t;

  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned SCHED_WORDS = 16;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] RND_PH1  = 7'd20;
  localparam logic [6:0] RND_PH2  = 7'd40;
  localparam logic [6:0] RND_PH3  = 7'd60;
  localparam logic [6:0] RND_LAST = 7'd79;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd4;
  localparam logic [63:0] LEN_STEP = 64'd8;

endpackage

// ----- rtl/sha1_message_digest.sv -----
// streaming sha-1 message digest, one message byte per input word
// depends on sha1_pkg (channel structs, states, constants)
//
// usage: the input channel (in_valid, in_stall, in_data) carries one byte
// per word with byte_valid and end_of_message flags. bytes pack big-endian
// into a 16-word schedule shift window. a full 64-byte block stalls the
// input through 80 rounds on the one shared round unit and the chaining
// add. end_of_message (with or without a byte) starts padding, fed byte
// by byte through the same packing path, with one or two compressions.
// the output channel (out_valid, out_stall, out_data) then gives five
// digest words, word 0 first, last_word on word 4, one per cycle unless
// stalled. a stalled word holds, and no input is taken until the fifth is
// accepted; the chaining state then returns to the initial vector.
// bytes within a block are taken one per cycle, so sustained rate is
// set by the single round unit, which takes no bytes while it compresses.
// reset (rst_n low, synchronous) clears the byte and length counts, loads
// the initial vector and leaves the block ready for a new message.
module sha1_message_digest (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha1_pkg::sha1_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha1_pkg::sha1_out_t out_data
);

  sha1_pkg::sha1_state_t state_r, state_nxt;

  logic [5:0]  fill_r;
  logic [23:0] acc_r;
  logic [31:0] w_r [sha1_pkg::SCHED_WORDS];
  logic [31:0] h_r [sha1_pkg::CHAIN_WORDS];
  logic [63:0] len_r;
  logic        mark_r, two_r, pad_r, done_r;
  logic [6:0]  rnd_r;
  logic [2:0]  wn_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;

  logic        byte_we, cnt_inc, pad_mark, len_shift;
  logic [7:0]  byte_val;
  logic        blk_full, in_acc, out_acc, finish;
  logic [31:0] f_val, k_val, t_val, w_new;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign finish   = out_acc && (wn_r == sha1_pkg::WORD_LAST);
  assign blk_full = byte_we && (fill_r == sha1_pkg::FILL_LAST);

  // control outputs per state
  always_comb begin
    byte_we   = 1'b0;
    cnt_inc   = 1'b0;
    pad_mark  = 1'b0;
    len_shift = 1'b0;
    byte_val  = in_data.data_byte;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      sha1_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.byte_valid) begin
          byte_we = 1'b1;
          cnt_inc = 1'b1;
        end
      end
      sha1_pkg::S_PAD: begin
        byte_we = 1'b1;
        if (!mark_r) begin
          byte_val = sha1_pkg::PAD_MARK;
          pad_mark = 1'b1;
        end else if (fill_r[5:3] == 3'h7 && !two_r) begin
          byte_val  = len_r[63:56];
          len_shift = 1'b1;
        end else begin
          byte_val = '0;
        end
      end
      sha1_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1_pkg::S_IDLE: begin
        if (in_valid) begin
          if (blk_full) state_nxt = sha1_pkg::S_ROUND;
          else if (in_data.end_of_message) state_nxt = sha1_pkg::S_PAD;
        end
      end
      sha1_pkg::S_PAD: begin
        if (blk_full) state_nxt = sha1_pkg::S_ROUND;
      end
      sha1_pkg::S_ROUND: begin
        if (rnd_r == sha1_pkg::RND_LAST) state_nxt = sha1_pkg::S_ADD;
      end
      sha1_pkg::S_ADD: begin
        if (done_r) state_nxt = sha1_pkg::S_OUT;
        else if (pad_r) state_nxt = sha1_pkg::S_PAD;
        else state_nxt = sha1_pkg::S_IDLE;
      end
      sha1_pkg::S_OUT: begin
        if (finish) state_nxt = sha1_pkg::S_IDLE;
      end
      default: state_nxt = sha1_pkg::S_IDLE;
    endcase
  end

  // shared round unit
  always_comb begin
    if (rnd_r < sha1_pkg::RND_PH1) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1_pkg::K0;
    end else if (rnd_r < sha1_pkg::RND_PH2) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K1;
    end else if (rnd_r < sha1_pkg::RND_PH3) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K3;
    end
    t_val = rotl(a_r, 5) + f_val + e_r + k_val + w_r[0];
    w_new = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
  end

  assign out_data.digest_word = h_r[0];
  assign out_data.word_number = wn_r;
  assign out_data.last_word   = (wn_r == sha1_pkg::WORD_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::S_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      mark_r  <= 1'b0;
      two_r   <= 1'b0;
      pad_r   <= 1'b0;
      done_r  <= 1'b0;
      rnd_r   <= '0;
      wn_r    <= '0;
      h_r[0]  <= sha1_pkg::IV0;
      h_r[1]  <= sha1_pkg::IV1;
      h_r[2]  <= sha1_pkg::IV2;
      h_r[3]  <= sha1_pkg::IV3;
      h_r[4]  <= sha1_pkg::IV4;
    end else begin
      state_r <= state_nxt;
      if (byte_we) fill_r <= fill_r + 6'd1;
      if (finish) len_r <= '0;
      else if (cnt_inc) len_r <= len_r + sha1_pkg::LEN_STEP;
      else if (len_shift) len_r <= {len_r[55:0], 8'h00};
      if (in_acc && in_data.end_of_message) pad_r <= 1'b1;
      else if (finish) pad_r <= 1'b0;
      if (pad_mark) mark_r <= 1'b1;
      else if (finish) mark_r <= 1'b0;
      // a block closing clears the two-block flag, marker late in block sets it
      if (byte_we && fill_r == sha1_pkg::FILL_LAST) two_r <= 1'b0;
      else if (pad_mark) two_r <= (fill_r[5:3] == 3'h7);
      if (len_shift && fill_r == sha1_pkg::FILL_LAST) done_r <= 1'b1;
      else if (finish) done_r <= 1'b0;
      if (state_r == sha1_pkg::S_ROUND) rnd_r <= rnd_r + 7'd1;
      else rnd_r <= '0;
      if (out_acc) wn_r <= finish ? 3'd0 : wn_r + 3'd1;
      if (finish) begin
        h_r[0] <= sha1_pkg::IV0;
        h_r[1] <= sha1_pkg::IV1;
        h_r[2] <= sha1_pkg::IV2;
        h_r[3] <= sha1_pkg::IV3;
        h_r[4] <= sha1_pkg::IV4;
      end else if (out_acc) begin
        for (int i = 0; i < sha1_pkg::CHAIN_WORDS - 1; i++) h_r[i] <= h_r[i+1];
        h_r[sha1_pkg::CHAIN_WORDS-1] <= h_r[0];
      end else if (state_r == sha1_pkg::S_ADD) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (byte_we) acc_r <= {acc_r[15:0], byte_val};
    // schedule window: w_r[0] is the word used by the current round
    if ((byte_we && fill_r[1:0] == 2'd3) || state_r == sha1_pkg::S_ROUND) begin
      for (int i = 0; i < sha1_pkg::SCHED_WORDS - 1; i++) w_r[i] <= w_r[i+1];
      w_r[sha1_pkg::SCHED_WORDS-1] <= (state_r == sha1_pkg::S_ROUND) ? w_new
                                                                    : {acc_r, byte_val};
    end
    if (blk_full) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (state_r == sha1_pkg::S_ROUND) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= rotl(b_r, 30);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    blk_full |=> state_r == sha1_pkg::S_ROUND)
    else $error("full block did not start rounds");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::S_ROUND && rnd_r == sha1_pkg::RND_LAST)
      |=> state_r == sha1_pkg::S_ADD)
    else $error("round 79 not followed by chaining add");

  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fill_r == 6'd0 && done_r && mark_r))
    else $error("digest output without a closed padded block");

  a_iv_restore: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (h_r[0] == sha1_pkg::IV0 && len_r == 64'd0 && !pad_r))
    else $error("state not returned to initial vector after digest");

endmodule

// ----- tb/sv/sha1_message_digest_tb.sv -----
// self-checking testbench for sha1_message_digest: byte stream in, digest words out
// depends on sha1_pkg and the sha1_message_digest rtl; carries its own sha-1 digest predictor
module sha1_message_digest_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sha1_pkg::sha1_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sha1_pkg::sha1_out_t out_data;

  sha1_message_digest DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // digest predictor state
  logic [31:0]         chain [sha1_pkg::CHAIN_WORDS];
  logic [7:0]          blk [64];
  logic [5:0]          fill;
  logic [60:0]         nbytes;
  sha1_pkg::sha1_out_t digest_q[$];

  sha1_pkg::sha1_in_t  feed_q[$];
  int          head = 0;
  int          n_sent = 0;
  int          n_total = 0;
  int          n_items = 0;
  int          n_msgs = 0;
  int          n_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // idling pattern follows how far the stimulus has got
  wire [1:0] load_phase = (n_total == 0) ? 2'd0 :
                          (n_sent * 3 >= n_total * 2) ? 2'd2 :
                          (n_sent * 3 >= n_total) ? 2'd1 : 2'd0;
  wire [6:0] feed_idle  = (load_phase == 0) ? 7'd24 : (load_phase == 1) ? 7'd47 : 7'd0;
  wire [6:0] drain_idle = (load_phase == 0) ? 7'd47 : (load_phase == 1) ? 7'd24 : 7'd0;

  function automatic void sha1_clear();
    chain[0] = sha1_pkg::IV0;
    chain[1] = sha1_pkg::IV1;
    chain[2] = sha1_pkg::IV2;
    chain[3] = sha1_pkg::IV3;
    chain[4] = sha1_pkg::IV4;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    fill = '0;
    nbytes = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [sha1_pkg::SCHED_WORDS];
    logic [31:0] a, b, c, d, e, f, k, t;
    int          j;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      j = r % 16;
      if (r >= 16) begin
        t = w[(j + 13) % 16] ^ w[(j + 8) % 16] ^ w[(j + 2) % 16] ^ w[j];
        w[j] = {t[30:0], t[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[j];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // absorb one accepted word, queue the digest when it closes a message
  function automatic void sha1_take(sha1_pkg::sha1_in_t w);
    logic [63:0]         bit_len;
    sha1_pkg::sha1_out_t r;
    if (w.byte_valid) begin
      blk[fill] = w.data_byte;
      fill = fill + 1'b1;
      nbytes = nbytes + 1'b1;
      if (fill == 0) sha1_compress();
    end
    if (!w.end_of_message) return;
    bit_len = {nbytes, 3'b000};
    blk[fill] = sha1_pkg::PAD_MARK;
    for (int i = int'(fill) + 1; i < 64; i++) blk[i] = 8'h00;
    // no room left for the length: one extra block
    if (fill >= 6'd56) begin
      sha1_compress();
      for (int i = 0; i < 56; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[56 + i] = bit_len[63 - 8*i -: 8];
    sha1_compress();
    for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
      r.digest_word = chain[i];
      r.word_number = i[2:0];
      r.last_word   = (r.word_number == sha1_pkg::WORD_LAST);
      digest_q.push_back(r);
    end
    sha1_clear();
  endfunction

  task automatic push_word(logic [7:0] b, logic v, logic e);
    sha1_pkg::sha1_in_t w;
    w.data_byte      = b;
    w.byte_valid     = v;
    w.end_of_message = e;
    feed_q.push_back(w);
    if (v || e) n_items++;
    if (e) n_msgs++;
  endtask

  task automatic push_message(int len, bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sha1_take(in_data);
        head++;
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (head < feed_q.size() && $urandom_range(99) >= feed_idle) begin
          in_valid <= 1'b1;
          in_data  <= feed_q[head];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once the sender stops idling
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && load_phase == 2'd2) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < drain_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    sha1_pkg::sha1_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected word: expected none, actual %h/%0d/%0d", $time,
                 out_data.digest_word, out_data.word_number, out_data.last_word);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          n_errors++;
          $display("%0t digest_word: expected %h, actual %h", $time,
                   want.digest_word, out_data.digest_word);
        end
        if (out_data.word_number !== want.word_number) begin
          n_errors++;
          $display("%0t word_number: expected %0d, actual %0d", $time,
                   want.word_number, out_data.word_number);
        end
        if (out_data.last_word !== want.last_word) begin
          n_errors++;
          $display("%0t last_word: expected %0d, actual %0d", $time,
                   want.last_word, out_data.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int len;
    sha1_clear();

    // directed: idle word, empty messages, extreme bytes, "abc", end without a byte
    push_word(8'hff, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hff, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    push_word(8'h55, 1'b1, 1'b0);
    push_word(8'haa, 1'b1, 1'b0);
    push_word(8'h5a, 1'b0, 1'b0);
    push_word(8'ha5, 1'b0, 1'b1);
    // length field no longer fits: two padding blocks
    push_message(56, 1'b0);
    // last byte fills the block and closes the message
    push_message(64, 1'b1);

    while (n_items < 140) begin
      len = $urandom_range(12);
      push_message(len, 1'($urandom_range(1)));
    end
    n_total = feed_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == feed_q.size());
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sha1_pkg.sv
rtl/sha1_message_digest.sv
tb/sv/sha1_message_digest_tb.sv
